/* rtl/ckrle_pkg.sv */
// shared types and constants for the color-keyed run-length line encoder
// no dependencies; imported by every module of the block
`default_nettype none

package ckrle_pkg;

    // field and position widths
    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 1;

    // parameter defaults
    localparam int DEF_LINE_MAX    = 255;
    localparam int DEF_STORE_DEPTH = 512;

    // configuration register reset values
    localparam logic [PIX_W-1:0] KEY_RESET   = 8'hFF;
    localparam logic [PIX_W-1:0] WIDTH_RESET = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b1;

    // input mode codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_KEY,       // transparent pixel accepted
        OP_GAP,       // opaque pixel after a gap: write gap count, open a set
        OP_PIX_IN,    // opaque pixel inside a run, taken from the input beat
        OP_PIX_HELD,  // opaque pixel held from the accept cycle
        OP_CNT,       // close the open set at line end
        OP_HDR,       // write the set count, mark the line ready
        OP_RD,        // read the next encoded byte from the store
        OP_OUT        // move the read byte into the output register
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_CNT,
        ST_HDR,
        ST_OUT
    } st_t;

    typedef struct packed {
        op_t op;
    } ckrle_cmd_t;

    typedef struct packed {
        logic line_ready;  // an encoded line waits to be drained
        logic in_clear;    // last pixel seen was transparent
        logic is_key;      // input pixel matches the color key
        logic end_next;    // line ends with the pixel now offered
        logic line_end;    // pixel count has reached the line width
        logic out_free;    // output register can take a beat this cycle
    } ckrle_stat_t;

endpackage

`default_nettype wire

/* rtl/colorkey_run_length_line_encoder_top.sv */
// top level of the color-keyed run-length line encoder
// depends on ckrle_pkg, ckrle_ctrl and ckrle_dpath
`default_nettype none

// one scanline of 8-bit palette pixels goes in as push beats (mode 0) and is
// encoded into an internal line store: a leading set-count byte, then per set
// a transparent count, an opaque count and the opaque pixel bytes; trailing
// transparent pixels are dropped, an all-transparent line is the single byte 0.
// once the line_width-th pixel is in, the line is drained with read beats
// (mode 1), one encoded byte per beat, last_byte marking the final one, after
// which the encoder starts the next line. push beats while a line waits, and
// read beats with no line waiting, are taken and dropped with no result.
// timing: the line store is a single-port memory, one access a cycle. a
// transparent pixel or an opaque one inside a run needs at most one store
// write; an opaque pixel that opens a run writes the gap count and then the
// pixel, and the last pixel of a line also closes the open set, if any, and
// writes the header. a read beat does a store read, then an output register
// load, which waits while out_stall holds the output register. in_stall is
// high while a beat is being worked on. color_key and line_width are to be
// written through the cfg port only while the block is idle; the block does
// not enforce this. line_width 0 acts as 1, above LINE_MAX as LINE_MAX.

module colorkey_run_length_line_encoder_top
    import ckrle_pkg::*;
#(
    parameter int LINE_MAX    = DEF_LINE_MAX,
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [PIX_W-1:0]     pixel,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [PIX_W-1:0]          out_byte,
    output logic                      last_byte
);

    ckrle_cmd_t  cmd;
    ckrle_stat_t stat;

    // sequencer: decides the store operations for each accepted beat
    ckrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // run counters, line store and output register
    ckrle_dpath #(
        .LINE_MAX    (LINE_MAX),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

/* rtl/ckrle_dpath.sv */
// datapath: configuration registers, run counters, line store and output register
// depends on ckrle_pkg; driven by ckrle_ctrl through ckrle_cmd_t
`default_nettype none

module ckrle_dpath
    import ckrle_pkg::*;
#(
    parameter int LINE_MAX    = DEF_LINE_MAX,
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data,
    input  wire logic [PIX_W-1:0]     pixel,
    input  wire logic                 out_stall,
    input  wire ckrle_cmd_t           cmd,
    output ckrle_stat_t               stat,
    output logic                      out_valid,
    output logic [PIX_W-1:0]          out_byte,
    output logic                      last_byte
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [PIX_W-1:0] LMAX = PIX_W'(LINE_MAX);
    localparam logic [POS_W:0]   DEPTH_LIM = (POS_W+1)'(STORE_DEPTH);

    logic [PIX_W-1:0] mem [STORE_DEPTH];

    logic [PIX_W-1:0] color_key_reg, color_key_next;
    logic [PIX_W-1:0] line_width_reg, line_width_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    logic [POS_W-1:0] count_slot_reg, count_slot_next;
    logic [POS_W-1:0] read_pos_reg, read_pos_next;
    logic [PIX_W-1:0] opaque_run_reg, opaque_run_next;
    logic [PIX_W-1:0] clear_run_reg, clear_run_next;
    logic [PIX_W-1:0] set_total_reg, set_total_next;
    logic [PIX_W-1:0] column_reg, column_next;
    logic             in_clear_reg, in_clear_next;
    logic             line_ready_reg, line_ready_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pix_hold_reg;
    logic [PIX_W-1:0] rdata_reg;
    logic             last_pend_reg;
    logic [PIX_W-1:0] out_byte_reg;
    logic             last_byte_reg;

    logic [PIX_W-1:0] eff_width;
    logic [PIX_W-1:0] column_inc;
    logic [POS_W-1:0] append_addr;
    logic             read_last;
    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    // clamp the configured width into 1..LINE_MAX
    always_comb
    begin
        if (line_width_reg == '0)
            eff_width = PIX_W'(1);
        else if (line_width_reg > LMAX)
            eff_width = LMAX;
        else
            eff_width = line_width_reg;
    end

    assign column_inc  = column_reg + PIX_W'(1);
    assign append_addr = write_pos_reg + POS_W'(1);
    assign read_last   = (read_pos_reg >= write_pos_reg);

    assign stat.line_ready = line_ready_reg;
    assign stat.in_clear   = in_clear_reg;
    assign stat.is_key     = (pixel == color_key_reg);
    assign stat.end_next   = (column_inc >= eff_width);
    assign stat.line_end   = (column_reg >= eff_width);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // configuration writes
    always_comb
    begin
        color_key_next  = color_key_reg;
        line_width_next = line_width_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLOR_KEY:  color_key_next  = cfg_data;
                REG_LINE_WIDTH: line_width_next = cfg_data;
                default: ;
            endcase
        end
    end

    // store write port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = append_addr;
        mem_wdata = pixel;
        unique case (cmd.op)
            OP_KEY:
            begin
                mem_we    = !in_clear_reg;
                mem_waddr = count_slot_reg;
                mem_wdata = opaque_run_reg;
            end
            OP_GAP:
            begin
                mem_we    = 1'b1;
                mem_wdata = clear_run_reg;
            end
            OP_PIX_IN:
            begin
                mem_we = 1'b1;
            end
            OP_PIX_HELD:
            begin
                mem_we    = 1'b1;
                mem_wdata = pix_hold_reg;
            end
            OP_CNT:
            begin
                mem_we    = 1'b1;
                mem_waddr = count_slot_reg;
                mem_wdata = opaque_run_reg;
            end
            OP_HDR:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = set_total_reg;
            end
            default: ;
        endcase
    end

    // encoder state update
    always_comb
    begin
        write_pos_next  = write_pos_reg;
        count_slot_next = count_slot_reg;
        read_pos_next   = read_pos_reg;
        opaque_run_next = opaque_run_reg;
        clear_run_next  = clear_run_reg;
        set_total_next  = set_total_reg;
        column_next     = column_reg;
        in_clear_next   = in_clear_reg;
        line_ready_next = line_ready_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (cmd.op)
            OP_KEY:
            begin
                if (!in_clear_reg)
                begin
                    set_total_next  = set_total_reg + PIX_W'(1);
                    opaque_run_next = '0;
                    in_clear_next   = 1'b1;
                end
                clear_run_next = clear_run_reg + PIX_W'(1);
                column_next    = column_inc;
            end
            OP_GAP:
            begin
                clear_run_next  = '0;
                count_slot_next = write_pos_reg + POS_W'(2);
                write_pos_next  = write_pos_reg + POS_W'(2);
                in_clear_next   = 1'b0;
                column_next     = column_inc;
            end
            OP_PIX_IN:
            begin
                write_pos_next  = append_addr;
                opaque_run_next = opaque_run_reg + PIX_W'(1);
                column_next     = column_inc;
            end
            OP_PIX_HELD:
            begin
                write_pos_next  = append_addr;
                opaque_run_next = opaque_run_reg + PIX_W'(1);
            end
            OP_CNT:
            begin
                set_total_next = set_total_reg + PIX_W'(1);
            end
            OP_HDR:
            begin
                line_ready_next = 1'b1;
                read_pos_next   = '0;
            end
            OP_RD:
            begin
                read_pos_next = read_pos_reg + POS_W'(1);
                // final byte: get ready for the next line
                if (read_last)
                begin
                    write_pos_next  = '0;
                    count_slot_next = '0;
                    read_pos_next   = '0;
                    opaque_run_next = '0;
                    clear_run_next  = '0;
                    set_total_next  = '0;
                    column_next     = '0;
                    in_clear_next   = 1'b1;
                    line_ready_next = 1'b0;
                end
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_key_reg  <= KEY_RESET;
            line_width_reg <= WIDTH_RESET;
            write_pos_reg  <= '0;
            count_slot_reg <= '0;
            read_pos_reg   <= '0;
            opaque_run_reg <= '0;
            clear_run_reg  <= '0;
            set_total_reg  <= '0;
            column_reg     <= '0;
            in_clear_reg   <= 1'b1;
            line_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            color_key_reg  <= color_key_next;
            line_width_reg <= line_width_next;
            write_pos_reg  <= write_pos_next;
            count_slot_reg <= count_slot_next;
            read_pos_reg   <= read_pos_next;
            opaque_run_reg <= opaque_run_next;
            clear_run_reg  <= clear_run_next;
            set_total_reg  <= set_total_next;
            column_reg     <= column_next;
            in_clear_reg   <= in_clear_next;
            line_ready_reg <= line_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_GAP)
            pix_hold_reg <= pixel;
        if (cmd.op == OP_RD)
            last_pend_reg <= read_last;
        if (cmd.op == OP_OUT)
        begin
            out_byte_reg  <= rdata_reg;
            last_byte_reg <= last_pend_reg;
        end
    end

    // single-port line store
    always_ff @(posedge clk)
    begin
        if (mem_we && ({1'b0, mem_waddr} < DEPTH_LIM))
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        else if (cmd.op == OP_RD)
            rdata_reg <= mem[read_pos_reg[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

`default_nettype wire

/* rtl/ckrle_ctrl.sv */
// controller: sequences store writes per pixel and the read-out of encoded bytes
// depends on ckrle_pkg; commands ckrle_dpath
`default_nettype none

module ckrle_ctrl
    import ckrle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        mode,
    input  wire ckrle_stat_t stat,
    output logic             in_stall,
    output ckrle_cmd_t       cmd
);

    st_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_PUSH)
                    begin
                        if (!stat.line_ready)
                        begin
                            if (stat.is_key)
                                state_next = stat.end_next ? ST_HDR : ST_IDLE;
                            else if (stat.in_clear)
                                state_next = ST_PIX;
                            else
                                state_next = stat.end_next ? ST_CNT : ST_IDLE;
                        end
                    end
                    else if (stat.line_ready)
                        state_next = ST_OUT;
                end
            end
            ST_PIX:  state_next = stat.line_end ? ST_CNT : ST_IDLE;
            ST_CNT:  state_next = ST_HDR;
            ST_HDR:  state_next = ST_IDLE;
            ST_OUT:  state_next = stat.out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = OP_NONE;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_PUSH)
                    begin
                        if (!stat.line_ready)
                        begin
                            if (stat.is_key)
                                cmd.op = OP_KEY;
                            else if (stat.in_clear)
                                cmd.op = OP_GAP;
                            else
                                cmd.op = OP_PIX_IN;
                        end
                    end
                    else if (stat.line_ready)
                        cmd.op = OP_RD;
                end
            end
            ST_PIX:  cmd.op = OP_PIX_HELD;
            ST_CNT:  cmd.op = OP_CNT;
            ST_HDR:  cmd.op = OP_HDR;
            ST_OUT:  cmd.op = stat.out_free ? OP_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire
